// ===== sv/udpf_pkg.sv =====
// Shared types and constants for the UDP receive filter and deframer.
package udpf_pkg;

  localparam int FRAME_MAX_DEF    = 16383;
  localparam int MAX_SEGMENTS_DEF = 16;

  // Config register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_LOCAL_IP     = 2'd0;
  localparam logic [1:0] REG_LOCAL_PORT   = 2'd1;
  localparam logic [1:0] REG_MATCH_ENABLE = 2'd2;

  // Verdict codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NOT_IP     = 3'd1;
  localparam logic [2:0] ST_OTHER_IP   = 3'd2;
  localparam logic [2:0] ST_NOT_UDP    = 3'd3;
  localparam logic [2:0] ST_OTHER_PORT = 3'd4;
  localparam logic [2:0] ST_BAD        = 3'd5;

  typedef struct packed {
    logic [31:0] local_ip;
    logic [15:0] local_port;
    logic        match_enable;
  } cfg_t;

  typedef struct packed {
    logic        data_valid;
    logic [7:0]  payload_byte;
    logic [3:0]  seg_index;
    logic        seg_end;
    logic        verdict_valid;
    logic [2:0]  status;
    logic [31:0] src_ip;
    logic [15:0] peer_port;
    logic [13:0] total_len;
  } result_t;

endpackage

// ===== sv/udpf_core.sv =====
// Per-byte frame parser: header checks, segment deframing and verdict.
module udpf_core import udpf_pkg::*; #(
  parameter int FRAME_MAX    = FRAME_MAX_DEF,
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  input  logic       frame_end,
  output result_t    res
);

  localparam int OFS_W     = $clog2(FRAME_MAX + 1);
  localparam int SEG_W     = $clog2(MAX_SEGMENTS + 1);
  localparam int LEN_LIMIT = (FRAME_MAX < 16383) ? FRAME_MAX : 16383;

  localparam logic [2:0] PH_HDR   = 3'd0;
  localparam logic [2:0] PH_COUNT = 3'd1;
  localparam logic [2:0] PH_LEN   = 3'd2;
  localparam logic [2:0] PH_DATA  = 3'd3;
  localparam logic [2:0] PH_DONE  = 3'd4;
  localparam logic [2:0] PH_DRAIN = 3'd5;

  logic [OFS_W-1:0] byte_offset, byte_offset_next;
  logic [2:0]       phase, phase_next;
  logic [2:0]       frame_status, frame_status_next;
  logic [23:0]      hdr_field, hdr_field_next;
  logic [15:0]      field_lo, field_lo_next;   // bytes 0-1 of a 64-bit field
  logic             field_hi, field_hi_next;   // any of bytes 2-7 nonzero
  logic [2:0]       field_cnt, field_cnt_next;
  logic [SEG_W-1:0] seg_total, seg_total_next;
  logic [SEG_W-1:0] seg_current, seg_current_next;
  logic [13:0]      seg_remaining, seg_remaining_next;
  logic [31:0]      sender_ip, sender_ip_next;
  logic [15:0]      sender_port, sender_port_next;
  logic [13:0]      payload_sum, payload_sum_next;

  logic [15:0]      fld_lo_v;
  logic             fld_hi_v;
  logic [SEG_W-1:0] seg_inc;
  logic [14:0]      len_sum;
  logic [2:0]       st;

  always_comb begin
    fld_lo_v = field_lo;
    fld_hi_v = field_hi;
    case (field_cnt)
      3'd0:    fld_lo_v[7:0]  = rx_byte;
      3'd1:    fld_lo_v[15:8] = rx_byte;
      default: fld_hi_v       = field_hi | (rx_byte != 8'd0);
    endcase
  end

  assign seg_inc = seg_current + 1'b1;
  assign len_sum = {1'b0, fld_lo_v[13:0]} + {1'b0, payload_sum};

  always_comb begin
    byte_offset_next   = byte_offset;
    phase_next         = phase;
    frame_status_next  = frame_status;
    hdr_field_next     = hdr_field;
    field_lo_next      = field_lo;
    field_hi_next      = field_hi;
    field_cnt_next     = field_cnt;
    seg_total_next     = seg_total;
    seg_current_next   = seg_current;
    seg_remaining_next = seg_remaining;
    sender_ip_next     = sender_ip;
    sender_port_next   = sender_port;
    payload_sum_next   = payload_sum;
    res                = '0;
    st                 = ST_OK;

    if (byte_offset >= OFS_W'(FRAME_MAX)) begin
      frame_status_next = ST_BAD;
      phase_next        = PH_DRAIN;
    end else begin
      byte_offset_next = byte_offset + 1'b1;
      unique case (phase) inside
        PH_HDR: begin
          unique case (byte_offset)
            OFS_W'(12): hdr_field_next = {16'd0, rx_byte};
            OFS_W'(13): begin
              if (!(hdr_field[7:0] == 8'h08 && rx_byte == 8'd0) && frame_status == ST_OK)
                frame_status_next = ST_NOT_IP;
            end
            OFS_W'(23): begin
              if (rx_byte != 8'd17 && frame_status == ST_OK)
                frame_status_next = ST_NOT_UDP;
            end
            OFS_W'(26): sender_ip_next[7:0]   = rx_byte;
            OFS_W'(27): sender_ip_next[15:8]  = rx_byte;
            OFS_W'(28): sender_ip_next[23:16] = rx_byte;
            OFS_W'(29): sender_ip_next[31:24] = rx_byte;
            OFS_W'(30): hdr_field_next = {16'd0, rx_byte};
            OFS_W'(31): hdr_field_next[15:8]  = rx_byte;
            OFS_W'(32): hdr_field_next[23:16] = rx_byte;
            OFS_W'(33): begin
              if (cfg.match_enable && {rx_byte, hdr_field[23:0]} != cfg.local_ip &&
                  (frame_status == ST_OK || frame_status == ST_NOT_UDP))
                frame_status_next = ST_OTHER_IP;
            end
            OFS_W'(34): sender_port_next[7:0]  = rx_byte;
            OFS_W'(35): sender_port_next[15:8] = rx_byte;
            OFS_W'(36): hdr_field_next = {16'd0, rx_byte};
            OFS_W'(37): begin
              hdr_field_next[15:8] = rx_byte;
              if (cfg.match_enable && {rx_byte, hdr_field[7:0]} != cfg.local_port &&
                  frame_status == ST_OK)
                frame_status_next = ST_OTHER_PORT;
            end
            default: ;
          endcase
          if (byte_offset >= OFS_W'(41)) begin
            field_lo_next  = '0;
            field_hi_next  = 1'b0;
            field_cnt_next = '0;
            phase_next     = (frame_status_next == ST_OK) ? PH_COUNT : PH_DRAIN;
          end
        end
        PH_COUNT, PH_LEN: begin
          if (field_cnt == 3'd7) begin
            field_lo_next  = '0;
            field_hi_next  = 1'b0;
            field_cnt_next = '0;
            if (phase == PH_COUNT) begin
              if (fld_hi_v || fld_lo_v > 16'(MAX_SEGMENTS)) begin
                frame_status_next = ST_BAD;
                phase_next        = PH_DRAIN;
              end else if (fld_lo_v == 16'd0) begin
                phase_next = PH_DONE;
              end else begin
                seg_total_next   = SEG_W'(fld_lo_v);
                seg_current_next = '0;
                phase_next       = PH_LEN;
              end
            end else begin
              if (fld_hi_v || fld_lo_v[15:14] != 2'd0 || len_sum > 15'(LEN_LIMIT)) begin
                frame_status_next = ST_BAD;
                phase_next        = PH_DRAIN;
              end else begin
                payload_sum_next = len_sum[13:0];
                if (fld_lo_v == 16'd0) begin
                  seg_current_next = seg_inc;
                  phase_next       = (seg_inc >= seg_total) ? PH_DONE : PH_LEN;
                end else begin
                  seg_remaining_next = fld_lo_v[13:0];
                  phase_next         = PH_DATA;
                end
              end
            end
          end else begin
            field_lo_next  = fld_lo_v;
            field_hi_next  = fld_hi_v;
            field_cnt_next = field_cnt + 1'b1;
          end
        end
        PH_DATA: begin
          res.data_valid     = 1'b1;
          res.payload_byte   = rx_byte;
          res.seg_index      = 4'(seg_current);
          res.seg_end        = (seg_remaining == 14'd1);
          seg_remaining_next = seg_remaining - 1'b1;
          if (seg_remaining == 14'd1) begin
            seg_current_next = seg_inc;
            phase_next       = (seg_inc >= seg_total) ? PH_DONE : PH_LEN;
          end
        end
        default: ;
      endcase
    end

    if (frame_end) begin
      st = frame_status_next;
      if (st == ST_OK && phase_next != PH_DONE)
        st = ST_BAD;
      if (st == ST_NOT_UDP && cfg.match_enable && byte_offset < OFS_W'(33))
        st = ST_BAD;
      res.verdict_valid  = 1'b1;
      res.status         = st;
      res.src_ip         = sender_ip_next;
      res.peer_port      = sender_port_next;
      res.total_len      = (st == ST_OK) ? payload_sum_next : 14'd0;
      byte_offset_next   = '0;
      phase_next         = PH_HDR;
      frame_status_next  = ST_OK;
      hdr_field_next     = '0;
      field_lo_next      = '0;
      field_hi_next      = 1'b0;
      field_cnt_next     = '0;
      seg_total_next     = '0;
      seg_current_next   = '0;
      seg_remaining_next = '0;
      sender_ip_next     = '0;
      sender_port_next   = '0;
      payload_sum_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset   <= '0;
      phase         <= PH_HDR;
      frame_status  <= ST_OK;
      hdr_field     <= '0;
      field_lo      <= '0;
      field_hi      <= 1'b0;
      field_cnt     <= '0;
      seg_total     <= '0;
      seg_current   <= '0;
      seg_remaining <= '0;
      sender_ip     <= '0;
      sender_port   <= '0;
      payload_sum   <= '0;
    end else if (accept) begin
      byte_offset   <= byte_offset_next;
      phase         <= phase_next;
      frame_status  <= frame_status_next;
      hdr_field     <= hdr_field_next;
      field_lo      <= field_lo_next;
      field_hi      <= field_hi_next;
      field_cnt     <= field_cnt_next;
      seg_total     <= seg_total_next;
      seg_current   <= seg_current_next;
      seg_remaining <= seg_remaining_next;
      sender_ip     <= sender_ip_next;
      sender_port   <= sender_port_next;
      payload_sum   <= payload_sum_next;
    end
  end

endmodule

// ===== sv/udp_rx_filter_deframer.sv =====
// Top level: APB config registers, parser and two-entry output buffer.
// A result beat is registered into out_reg when its input beat is accepted, or into skid_reg if out_reg is held.
// One input beat per cycle while s_tready is high; the parser updates its state on each accepted beat.
// A two-entry output buffer keeps s_tready high while one result waits on m_tready.
// Reset (rst, synchronous) clears the config registers to 0 and all frame state;
// the next beat is taken as byte 0 of a new frame.
module udp_rx_filter_deframer import udpf_pkg::*; #(
  parameter int FRAME_MAX    = FRAME_MAX_DEF,
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // rx_byte
  input  logic        s_tlast,   // frame_end
  output logic        m_tvalid,
  input  logic        m_tready,
  // payload_byte[7:0], seg_index[11:8], seg_end[12], status[15:13],
  // src_ip[47:16], sender port[63:48], total_len[77:64], zero[79:78]
  output logic [79:0] m_tdata,
  output logic        m_tlast,   // verdict_valid
  output logic        m_tuser,   // data_valid
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t    cfg;
  result_t res;
  result_t out_reg, skid_reg;
  logic    skid_valid;
  logic    accept, pop, cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_LOCAL_IP:     cfg.local_ip     <= pwdata;
        REG_LOCAL_PORT:   cfg.local_port   <= pwdata[15:0];
        REG_MATCH_ENABLE: cfg.match_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_LOCAL_IP:     prdata = cfg.local_ip;
      REG_LOCAL_PORT:   prdata = {16'd0, cfg.local_port};
      REG_MATCH_ENABLE: prdata = {31'd0, cfg.match_enable};
      default:          prdata = 32'd0;
    endcase
  end

  udpf_core #(
    .FRAME_MAX    (FRAME_MAX),
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (accept),
    .rx_byte   (s_tdata),
    .frame_end (s_tlast),
    .res       (res)
  );

  assign s_tready = ~skid_valid;
  assign accept   = s_tvalid & s_tready;
  assign pop      = m_tvalid & m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (!m_tvalid || pop) begin
        m_tvalid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) out_reg <= skid_reg;
    end else if (accept) begin
      if (!m_tvalid || pop) out_reg <= res;
      else skid_reg <= res;
    end
  end

  assign m_tdata = {2'b00, out_reg.total_len, out_reg.peer_port, out_reg.src_ip,
                    out_reg.status, out_reg.seg_end, out_reg.seg_index,
                    out_reg.payload_byte};
  assign m_tlast = out_reg.verdict_valid;
  assign m_tuser = out_reg.data_valid;

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the UDP receive filter and deframer.
`timescale 1ns / 1ps

module tb_top import udpf_pkg::*; ();

  localparam int NO_CHECK  = -1;
  localparam int LEN_LIMIT = (FRAME_MAX_DEF < 16383) ? FRAME_MAX_DEF : 16383;

  localparam logic [31:0] LIP = 32'h0100_A8C0;
  localparam logic [31:0] OIP = 32'h0200_A8C0;
  localparam logic [15:0] LPT = 16'h3412;
  localparam logic [15:0] OPT = 16'h3512;
  localparam logic [31:0] SIP = 32'h0500_000A;
  localparam logic [15:0] SPT = 16'hD204;

  typedef enum logic [2:0] {
    PS_HEADER, PS_COUNT, PS_LENGTH, PS_PAYLOAD, PS_DONE, PS_DRAIN
  } parse_phase_t;

  typedef struct packed {
    logic [31:0] cfg_ip;
    logic [15:0] cfg_port;
    logic        cfg_me;
    logic [15:0] etype;
    logic [7:0]  proto;
    logic [31:0] dst_ip;
    logic [15:0] dest_port;
    logic [31:0] src_ip;
    logic [15:0] peer_port;
    logic [63:0] count;
    logic [63:0] len;
    int          cut;   // truncate to this many bytes, 0 = whole frame
    int          pad;   // trailing bytes after the last segment
    int          want;  // verdict status typed in, or NO_CHECK
  } frame_row_t;

  localparam frame_row_t DIR_ROWS [22] = '{
    '{32'h0, 16'h0, 1'b0, 16'h0800, 8'd17, LIP, LPT, 32'h0, 16'h0,
      64'd1, 64'd1, 0, 0, int'(ST_OK)},
    '{32'h0, 16'h0, 1'b0, 16'h0008, 8'd17, LIP, LPT, SIP, SPT,
      64'd1, 64'd4, 0, 0, int'(ST_NOT_IP)},
    '{32'h0, 16'h0, 1'b0, 16'h86DD, 8'd17, LIP, LPT, SIP, SPT,
      64'd1, 64'd4, 0, 0, int'(ST_NOT_IP)},
    '{32'h0, 16'h0, 1'b0, 16'h0800, 8'd6, LIP, LPT, SIP, SPT,
      64'd1, 64'd4, 0, 0, int'(ST_NOT_UDP)},
    '{LIP, LPT, 1'b1, 16'h0800, 8'd17, LIP, LPT, 32'hFFFF_FFFF, 16'hFFFF,
      64'd16, 64'd1, 0, 0, int'(ST_OK)},
    // wrong address outranks wrong protocol
    '{LIP, LPT, 1'b1, 16'h0800, 8'd6, OIP, LPT, SIP, SPT,
      64'd1, 64'd4, 0, 0, int'(ST_OTHER_IP)},
    '{LIP, LPT, 1'b1, 16'h0800, 8'd17, LIP, OPT, SIP, SPT,
      64'd1, 64'd4, 0, 0, int'(ST_OTHER_PORT)},
    // not UDP, ends before the address is known
    '{LIP, LPT, 1'b1, 16'h0800, 8'd6, LIP, LPT, SIP, SPT,
      64'd1, 64'd4, 30, 0, int'(ST_BAD)},
    '{LIP, LPT, 1'b1, 16'h0800, 8'd6, LIP, LPT, SIP, SPT,
      64'd1, 64'd4, 34, 0, int'(ST_NOT_UDP)},
    '{LIP, LPT, 1'b1, 16'h0800, 8'd17, LIP, LPT, SIP, SPT,
      64'd17, 64'd4, 0, 0, int'(ST_BAD)},
    '{LIP, LPT, 1'b1, 16'h0800, 8'd17, LIP, LPT, SIP, SPT,
      64'd0, 64'd0, 0, 0, int'(ST_OK)},
    '{LIP, LPT, 1'b1, 16'h0800, 8'd17, LIP, LPT, SIP, SPT,
      64'h0100_0000_0000_0001, 64'd4, 0, 0, int'(ST_BAD)},
    '{LIP, LPT, 1'b1, 16'h0800, 8'd17, LIP, LPT, SIP, SPT,
      64'd1, 64'd16384, 70, 0, int'(ST_BAD)},
    '{LIP, LPT, 1'b1, 16'h0800, 8'd17, LIP, LPT, SIP, SPT,
      64'd1, 64'd16383, 70, 0, int'(ST_BAD)},
    '{LIP, LPT, 1'b1, 16'h0800, 8'd17, LIP, LPT, SIP, SPT,
      64'd3, 64'd0, 0, 0, int'(ST_OK)},
    '{LIP, LPT, 1'b1, 16'h0800, 8'd17, LIP, LPT, SIP, SPT,
      64'd2, 64'd5, 60, 0, int'(ST_BAD)},
    '{LIP, LPT, 1'b1, 16'h0800, 8'd17, LIP, LPT, SIP, SPT,
      64'd1, 64'd7, 0, 9, int'(ST_OK)},
    '{LIP, LPT, 1'b1, 16'h0800, 8'd17, LIP, LPT, SIP, SPT,
      64'd1, 64'd1, 1, 0, int'(ST_BAD)},
    '{32'hFFFF_FFFF, 16'hFFFF, 1'b1, 16'h0800, 8'd17, 32'hFFFF_FFFF, 16'hFFFF, SIP, SPT,
      64'd2, 64'd3, 0, 0, int'(ST_OK)},
    '{32'h0, 16'h0, 1'b1, 16'h0800, 8'd17, 32'h0, 16'h0, SIP, SPT,
      64'd1, 64'd2, 0, 0, int'(ST_OK)},
    '{32'h0, 16'h0, 1'b0, 16'h0800, 8'd17, LIP, LPT, SIP, SPT,
      64'd4, 64'd40, 0, 0, NO_CHECK},
    '{32'h0, 16'h0, 1'b0, 16'h0800, 8'd17, LIP, LPT, SIP, SPT,
      64'd1, 64'hFF00_0000_0000_0000, 70, 0, int'(ST_BAD)}
  };

  localparam int IDLE_SEND  [4] = '{0, 75, 0, 11};
  localparam int IDLE_STALL [4] = '{0, 0, 75, 11};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b1;
  logic [79:0] m_tdata;
  logic        m_tlast;
  logic        m_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = 4'h0;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  udp_rx_filter_deframer i_dut (.*);

  always #1 clk = ~clk;

  // filter/deframer state mirror
  logic [31:0]  cf_ip = '0;
  logic [15:0]  cf_port = '0;
  logic         cf_match = 1'b0;
  logic [13:0]  pr_off;
  parse_phase_t pr_phase;
  logic [2:0]   pr_status;
  logic [63:0]  pr_shift;
  int           pr_nbytes;
  logic [4:0]   pr_seg_total;
  logic [4:0]   pr_seg_cur;
  logic [13:0]  pr_seg_left;
  logic [31:0]  pr_src_ip;
  logic [15:0]  pr_src_port;
  logic [13:0]  pr_sum;

  result_t    verdict_q [$];
  logic [7:0] frame_q [$];

  int fails = 0;
  int n_beats = 0;
  int n_frames = 0;
  int n_verdicts = 0;
  int n_accepted = 0;
  int n_payload = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;

  function automatic void clear_frame_state();
    pr_off = '0;
    pr_phase = PS_HEADER;
    pr_status = ST_OK;
    pr_shift = '0;
    pr_nbytes = 0;
    pr_seg_total = '0;
    pr_seg_cur = '0;
    pr_seg_left = '0;
    pr_src_ip = '0;
    pr_src_port = '0;
    pr_sum = '0;
  endfunction

  initial clear_frame_state();

  function automatic void go_malformed();
    pr_status = ST_BAD;
    pr_phase = PS_DRAIN;
  endfunction

  function automatic void advance_segment();
    pr_seg_cur = pr_seg_cur + 5'd1;
    pr_phase = (pr_seg_cur >= pr_seg_total) ? PS_DONE : PS_LENGTH;
  endfunction

  // little-endian 64-bit field assembly; returns 1 when all 8 bytes are in
  function automatic bit take_field_byte(input logic [7:0] b, output logic [63:0] v);
    pr_shift = pr_shift | (64'(b) << (8 * pr_nbytes));
    pr_nbytes++;
    v = pr_shift;
    if (pr_nbytes < 8) return 1'b0;
    pr_shift = '0;
    pr_nbytes = 0;
    return 1'b1;
  endfunction

  function automatic result_t filter_step(input logic [7:0] b, input logic last);
    result_t     r;
    logic [13:0] pos;
    logic [63:0] v;
    logic [2:0]  st;
    r = '0;
    pos = pr_off;
    if (int'(pos) >= FRAME_MAX_DEF) go_malformed();
    else pr_off = pr_off + 14'd1;

    case (pr_phase)
      PS_HEADER: begin
        if (pos == 12) begin
          pr_shift = 64'(b);
        end else if (pos == 13) begin
          if (!(pr_shift == 64'h08 && b == 8'h00) && pr_status == ST_OK)
            pr_status = ST_NOT_IP;
        end else if (pos == 23) begin
          if (b != 8'd17 && pr_status == ST_OK) pr_status = ST_NOT_UDP;
        end else if (pos >= 26 && pos <= 29) begin
          pr_src_ip = pr_src_ip | (32'(b) << (8 * (pos - 26)));
        end else if (pos == 30) begin
          pr_shift = 64'(b);
        end else if (pos >= 31 && pos <= 33) begin
          pr_shift = pr_shift | (64'(b) << (8 * (pos - 30)));
          // address check ranks above the protocol check
          if (pos == 33 && cf_match && pr_shift[31:0] != cf_ip &&
              (pr_status == ST_OK || pr_status == ST_NOT_UDP))
            pr_status = ST_OTHER_IP;
        end else if (pos == 34 || pos == 35) begin
          pr_src_port = pr_src_port | (16'(b) << (8 * (pos - 34)));
        end else if (pos == 36) begin
          pr_shift = 64'(b);
        end else if (pos == 37) begin
          pr_shift = pr_shift | (64'(b) << 8);
          if (cf_match && pr_shift[15:0] != cf_port && pr_status == ST_OK)
            pr_status = ST_OTHER_PORT;
        end
        if (pos >= 41) begin
          pr_shift = '0;
          pr_nbytes = 0;
          pr_phase = (pr_status == ST_OK) ? PS_COUNT : PS_DRAIN;
        end
      end
      PS_COUNT: begin
        if (take_field_byte(b, v)) begin
          if (v > 64'(MAX_SEGMENTS_DEF)) begin
            go_malformed();
          end else if (v == 0) begin
            pr_phase = PS_DONE;
          end else begin
            pr_seg_total = v[4:0];
            pr_seg_cur = '0;
            pr_phase = PS_LENGTH;
          end
        end
      end
      PS_LENGTH: begin
        if (take_field_byte(b, v)) begin
          if (v > 64'(LEN_LIMIT) - 64'(pr_sum)) begin
            go_malformed();
          end else begin
            pr_sum = pr_sum + v[13:0];
            if (v == 0) begin
              advance_segment();
            end else begin
              pr_seg_left = v[13:0];
              pr_phase = PS_PAYLOAD;
            end
          end
        end
      end
      PS_PAYLOAD: begin
        r.data_valid = 1'b1;
        r.payload_byte = b;
        r.seg_index = pr_seg_cur[3:0];
        r.seg_end = (pr_seg_left == 14'd1);
        pr_seg_left = pr_seg_left - 14'd1;
        if (pr_seg_left == 0) advance_segment();
      end
      default: ;
    endcase

    if (last) begin
      st = pr_status;
      if (st == ST_OK && pr_phase != PS_DONE) st = ST_BAD;
      if (st == ST_NOT_UDP && cf_match && pos < 33) st = ST_BAD;
      r.verdict_valid = 1'b1;
      r.status = st;
      r.src_ip = pr_src_ip;
      r.peer_port = pr_src_port;
      r.total_len = (st == ST_OK) ? pr_sum : 14'd0;
      clear_frame_state();
    end
    return r;
  endfunction

  function automatic void note_mismatch(input string what, input logic [63:0] want,
                                        input logic [63:0] got);
    fails++;
    if (fails <= 10)
      $display("mismatch %s: expected %0h, got %0h at %0t", what, want, got, $realtime);
  endfunction

  // result monitor
  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.data_valid = m_tuser;
      got.payload_byte = m_tdata[7:0];
      got.seg_index = m_tdata[11:8];
      got.seg_end = m_tdata[12];
      got.status = m_tdata[15:13];
      got.src_ip = m_tdata[47:16];
      got.peer_port = m_tdata[63:48];
      got.total_len = m_tdata[77:64];
      got.verdict_valid = m_tlast;
      if (got.verdict_valid) begin
        n_verdicts++;
        if (got.status == ST_OK) n_accepted++;
      end
      if (got.data_valid) n_payload++;
      if (verdict_q.size() == 0) begin
        note_mismatch("unexpected beat", 64'h0, {m_tuser, m_tlast, m_tdata[61:0]});
      end else begin
        want = verdict_q[0];
        verdict_q.delete(0);
        if (got.data_valid !== want.data_valid)
          note_mismatch("data_valid", want.data_valid, got.data_valid);
        if (got.payload_byte !== want.payload_byte)
          note_mismatch("payload_byte", want.payload_byte, got.payload_byte);
        if (got.seg_index !== want.seg_index)
          note_mismatch("seg_index", want.seg_index, got.seg_index);
        if (got.seg_end !== want.seg_end)
          note_mismatch("seg_end", want.seg_end, got.seg_end);
        if (got.verdict_valid !== want.verdict_valid)
          note_mismatch("verdict_valid", want.verdict_valid, got.verdict_valid);
        if (got.status !== want.status)
          note_mismatch("status", want.status, got.status);
        if (got.src_ip !== want.src_ip)
          note_mismatch("src_ip", want.src_ip, got.src_ip);
        if (got.peer_port !== want.peer_port)
          note_mismatch("sender port", want.peer_port, got.peer_port);
        if (got.total_len !== want.total_len)
          note_mismatch("total_len", want.total_len, got.total_len);
      end
    end
  end

  always @(negedge clk) m_tready <= ($urandom_range(0, 99) >= stall_pct);

  task automatic send_beat(input logic [7:0] b, input logic last, input int forced);
    result_t r;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    r = filter_step(b, last);
    if (last && forced >= 0) r.status = 3'(forced);
    verdict_q.insert(verdict_q.size(), r);
    n_beats++;
    @(negedge clk);
  endtask

  // hold_at: beat index before which the sender waits for every result
  task automatic send_frame(input int forced, input int hold_at);
    for (int i = 0; i < frame_q.size(); i++) begin
      if (i == hold_at) begin
        s_tvalid <= 1'b0;
        do @(posedge clk); while (verdict_q.size() != 0);
        @(negedge clk);
      end
      send_beat(frame_q[i], i == frame_q.size() - 1, forced);
    end
    n_frames++;
  endtask

  task automatic build_frame(input frame_row_t fr);
    int nseg;
    int plen;
    frame_q.delete();
    for (int i = 0; i < 42; i++) frame_q.insert(frame_q.size(), 8'($urandom));
    frame_q[12] = fr.etype[15:8];
    frame_q[13] = fr.etype[7:0];
    frame_q[23] = fr.proto;
    for (int i = 0; i < 4; i++) begin
      frame_q[26 + i] = fr.src_ip[8*i +: 8];
      frame_q[30 + i] = fr.dst_ip[8*i +: 8];
    end
    for (int i = 0; i < 2; i++) begin
      frame_q[34 + i] = fr.peer_port[8*i +: 8];
      frame_q[36 + i] = fr.dest_port[8*i +: 8];
    end
    for (int i = 0; i < 8; i++) frame_q.insert(frame_q.size(), fr.count[8*i +: 8]);
    nseg = (fr.count > 64'd16) ? 2 : int'(fr.count);
    plen = (fr.len > 64'd16383) ? 16 : int'(fr.len);
    for (int s = 0; s < nseg; s++) begin
      for (int i = 0; i < 8; i++) frame_q.insert(frame_q.size(), fr.len[8*i +: 8]);
      for (int i = 0; i < plen; i++) frame_q.insert(frame_q.size(), 8'($urandom));
    end
    for (int i = 0; i < fr.pad; i++) frame_q.insert(frame_q.size(), 8'($urandom));
    if (fr.cut > 0)
      while (frame_q.size() > fr.cut) void'(frame_q.pop_back());
  endtask

  // wait until the block has nothing in flight
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (verdict_q.size() != 0);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apb_xfer(input logic wr, input logic [3:0] addr, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_config(input logic [31:0] ip, input logic [15:0] port,
                              input logic me);
    logic [31:0] vals [3];
    logic [31:0] rd;
    vals[REG_LOCAL_IP] = ip;
    vals[REG_LOCAL_PORT] = {16'h0, port};
    vals[REG_MATCH_ENABLE] = {31'h0, me};
    wait_idle();
    for (int i = REG_LOCAL_IP; i <= REG_MATCH_ENABLE; i++) begin
      apb_xfer(1'b1, 4'(4 * i), vals[i], rd);
      apb_xfer(1'b0, 4'(4 * i), 32'h0, rd);
      if (rd !== vals[i]) note_mismatch("register readback", vals[i], rd);
    end
    cf_ip = ip;
    cf_port = port;
    cf_match = me;
  endtask

  initial begin
    #1_000_000;
    $display("tb_top failed");
    $finish;
  end

  initial begin
    frame_row_t fr;
    int         roll;
    int         ph_start;
    int         ph_frames;
    int         hold;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed frames, no idling
    for (int k = 0; k < 22; k++) begin
      fr = DIR_ROWS[k];
      if ({fr.cfg_ip, fr.cfg_port, fr.cfg_me} != {cf_ip, cf_port, cf_match})
        write_config(fr.cfg_ip, fr.cfg_port, fr.cfg_me);
      build_frame(fr);
      send_frame(fr.want, NO_CHECK);
    end

    // random frames, one config and idling pattern per phase
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_config($urandom, 16'($urandom), 1'b0);
        1: write_config(32'hFFFF_FFFF, 16'hFFFF, 1'b1);
        2: write_config(32'h0, 16'h0, 1'b1);
        default: write_config($urandom, 16'($urandom), 1'b1);
      endcase
      send_idle_pct = IDLE_SEND[ph];
      stall_pct = IDLE_STALL[ph];
      ph_start = n_beats;
      ph_frames = 0;
      while (n_beats - ph_start < 100 || ph_frames < 4) begin
        roll = $urandom_range(0, 99);
        if (roll < 6) begin
          // line noise
          frame_q.delete();
          repeat ($urandom_range(1, 60)) frame_q.insert(frame_q.size(), 8'($urandom));
        end else begin
          fr = '0;
          fr.etype = ($urandom_range(0, 99) < 90) ? 16'h0800 : 16'($urandom);
          fr.proto = ($urandom_range(0, 99) < 90) ? 8'd17 : 8'($urandom);
          fr.dst_ip = ($urandom_range(0, 99) < 85) ? cf_ip : $urandom;
          fr.dest_port = ($urandom_range(0, 99) < 85) ? cf_port : 16'($urandom);
          fr.src_ip = $urandom;
          fr.peer_port = 16'($urandom);
          roll = $urandom_range(0, 99);
          if (roll < 65) fr.count = 64'($urandom_range(0, 3));
          else if (roll < 85) fr.count = 64'($urandom_range(4, 16));
          else if (roll < 93) fr.count = 64'($urandom_range(17, 255));
          else fr.count = {$urandom, $urandom};
          roll = $urandom_range(0, 99);
          if (roll < 80) fr.len = 64'($urandom_range(0, 12));
          else if (roll < 94) fr.len = 64'($urandom_range(13, 40));
          else if (roll < 97) fr.len = 64'(16380 + $urandom_range(0, 8));
          else fr.len = {$urandom, $urandom};
          fr.pad = ($urandom_range(0, 99) < 30) ? $urandom_range(1, 5) : 0;
          if (fr.len > 64'd100) fr.cut = $urandom_range(45, 90);
          else fr.cut = ($urandom_range(0, 99) < 12) ? $urandom_range(1, 120) : 0;
          build_frame(fr);
        end
        hold = (ph == 2 && ph_frames == 1 && frame_q.size() > 1) ?
               $urandom_range(1, frame_q.size() - 1) : NO_CHECK;
        send_frame(NO_CHECK, hold);
        ph_frames++;
      end
    end

    s_tvalid <= 1'b0;
    do @(posedge clk); while (verdict_q.size() != 0);
    repeat (10) @(posedge clk);

    $display("%0d frames in %0d byte beats: %0d verdicts, %0d accepted, %0d payload bytes",
             n_frames, n_beats, n_verdicts, n_accepted, n_payload);
    $display("bound and unbound filtering, size limits, no idling and three idling mixes");
    if (fails == 0) begin
      $display("tb_top passed");
    end else begin
      $display("%0d mismatches", fails);
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/udpf_pkg.sv
sv/udpf_core.sv
sv/udp_rx_filter_deframer.sv
dv/tb_top.sv
